// ===== src/rcls_pkg.sv =====
// ----------------------------------------------------------------------------
// rcls_pkg
// Shared widths and result codes for the random clause literal sampler.
// ----------------------------------------------------------------------------
package rcls_pkg;

   // field widths
   localparam int WORD_W   = 31;
   localparam int NVARS_W  = 31;
   localparam int CWIDTH_W = 5;
   localparam int NCL_W    = 32;
   localparam int LIT_W    = 32;
   localparam int STATUS_W = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;
   localparam int STEP_W   = 5;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_ACCEPT  = 2'd0,
      STATUS_REPEAT  = 2'd1,
      STATUS_CFG_ERR = 2'd2
   } status_type;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_VAR_COUNT    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CLAUSE_WIDTH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_CLAUSES  = 2'd2;

   // reset values of the configuration registers
   localparam logic [NVARS_W-1:0]  VAR_COUNT_RST    = 31'd3;
   localparam logic [CWIDTH_W-1:0] CLAUSE_WIDTH_RST = 5'd3;
   localparam logic [NCL_W-1:0]    NUM_CLAUSES_RST  = 32'd1;

endpackage

// ===== src/rcls_ram.sv =====
// ----------------------------------------------------------------------------
// rcls_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rcls_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/random_clause_literal_sampler_top.sv =====
// ----------------------------------------------------------------------------
// random_clause_literal_sampler_top
// Maps random words to signed k-SAT literals, rejects repeated variables
// within a clause and flags the ends of clauses and formulas.
// ----------------------------------------------------------------------------
//  channel | direction | tdata                | tuser                    | tlast
//  req_    | in        | [30:0] random_word   | -                        | -
//  rsp_    | out       | [31:0] literal       | [1:0] status,            | clause_done
//          |           |                      | [2] formula_done         |
//  csr_    | in        | write only: csr_we, csr_index, csr_wdata          |
//
//  One beat goes through these steps in order: accept, the bit-serial restoring
//  modulo by twice the variable count, forming the literal, a scan of the clause
//  store through its single read port (a repeated variable ends the scan at the
//  first hit), and emit. A configuration error skips straight to emit.
//  req_tready is high only between beats; a held result in the rsp_ register
//  does not block the next accept, only the emit of the next result. Reset is
//  synchronous and returns position, clause count and configuration to their
//  reset values; the clause store is not cleared.
// ----------------------------------------------------------------------------
module random_clause_literal_sampler_top #(
   parameter int WIDTH_MAX = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   // input channel
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [31:0]                     req_tdata,  // [30:0] random_word
   // result channel
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [31:0]                     rsp_tdata,  // [31:0] literal
   output logic [2:0]                      rsp_tuser,  // [1:0] status, [2] formula_done
   output logic                            rsp_tlast,  // clause_done
   // configuration port
   input  logic                            csr_we,
   input  logic [rcls_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rcls_pkg::CSR_DATA_W-1:0] csr_wdata
);

   import rcls_pkg::*;

   localparam int AW = (WIDTH_MAX > 1) ? $clog2(WIDTH_MAX) : 1;
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(WORD_W - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_LIT,
      ST_SCAN,
      ST_EMIT
   } state_type;

   // configuration
   logic [NVARS_W-1:0]  nvars_ff, nvars_in;
   logic [CWIDTH_W-1:0] cwidth_ff, cwidth_in;
   logic [NCL_W-1:0]    nclauses_ff, nclauses_in;

   // sequencer and datapath
   state_type           state_ff, state_in;
   logic [WORD_W-1:0]   word_ff, word_in;
   logic [31:0]         rem_ff, rem_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [NVARS_W-1:0]  mag_ff, mag_in;
   logic                neg_ff, neg_in;
   logic [AW-1:0]       scan_ff, scan_in;
   logic                chk_vld_ff, chk_vld_in;
   status_type          res_status_ff, res_status_in;

   // clause state
   logic [AW-1:0]       pos_ff, pos_in;
   logic [NCL_W-1:0]    ccount_ff, ccount_in;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [LIT_W-1:0]    rsp_lit_ff, rsp_lit_in;
   logic                rsp_cdone_ff, rsp_cdone_in;
   logic                rsp_fdone_ff, rsp_fdone_in;

   // combinational helpers
   logic [31:0]         dvsr;
   logic [32:0]         trial;
   logic [32:0]         diff;
   logic                cfg_err;
   logic                issue;
   logic                match;
   logic                clause_end;
   logic                formula_end;
   logic [LIT_W-1:0]    lit_val;
   logic [31:0]         neg_mag;
   logic                ram_we;
   logic [NVARS_W-1:0]  ram_rdata;

   // clause store: magnitudes of accepted literals
   rcls_ram #(
      .WIDTH (NVARS_W),
      .DEPTH (WIDTH_MAX)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (pos_ff),
      .wr_data (mag_ff),
      .rd_en   (issue),
      .rd_addr (scan_ff),
      .rd_data (ram_rdata)
   );

   // shared compare/subtract unit of the restoring modulo
   assign dvsr  = {nvars_ff, 1'b0};
   assign trial = {rem_ff, word_ff[WORD_W-1]};
   assign diff  = trial - {1'b0, dvsr};

   // configuration sanity
   assign cfg_err = (nvars_ff == '0) || (cwidth_ff == '0) ||
                    ({27'd0, cwidth_ff} > 32'(WIDTH_MAX)) ||
                    ({27'd0, cwidth_ff} > {1'b0, nvars_ff});

   // store scan: one read issued and one compare per cycle
   assign issue = (state_ff == ST_SCAN) && (scan_ff != pos_ff) &&
                  !(chk_vld_ff && (ram_rdata == mag_ff));
   assign match = chk_vld_ff && (ram_rdata == mag_ff);

   // clause and formula end
   assign clause_end  = ({{(33 - AW){1'b0}}, pos_ff} + 33'd1) >= {28'd0, cwidth_ff};
   assign formula_end = ({1'b0, ccount_ff} + 33'd1) >= {1'b0, nclauses_ff};

   assign neg_mag = rem_ff - {1'b0, nvars_ff} + 32'd1;
   assign lit_val = neg_ff ? (32'd0 - {1'b0, mag_ff}) : {1'b0, mag_ff};

   assign ram_we = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_tready) &&
                   (res_status_ff == STATUS_ACCEPT);

   // next-state logic
   always_comb begin
      nvars_in      = nvars_ff;
      cwidth_in     = cwidth_ff;
      nclauses_in   = nclauses_ff;
      state_in      = state_ff;
      word_in       = word_ff;
      rem_in        = rem_ff;
      step_in       = step_ff;
      mag_in        = mag_ff;
      neg_in        = neg_ff;
      scan_in       = scan_ff;
      chk_vld_in    = chk_vld_ff;
      res_status_in = res_status_ff;
      pos_in        = pos_ff;
      ccount_in     = ccount_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_lit_in    = rsp_lit_ff;
      rsp_cdone_in  = rsp_cdone_ff;
      rsp_fdone_in  = rsp_fdone_ff;

      // register writes
      if (csr_we) begin
         case (csr_index)
            CSR_VAR_COUNT:    nvars_in    = csr_wdata[NVARS_W-1:0];
            CSR_CLAUSE_WIDTH: cwidth_in   = csr_wdata[CWIDTH_W-1:0];
            CSR_NUM_CLAUSES:  nclauses_in = csr_wdata[NCL_W-1:0];
            default:          ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            // take a beat, reject bad configuration at once
            if (req_tvalid) begin
               word_in = req_tdata[WORD_W-1:0];
               rem_in  = '0;
               step_in = '0;
               if (cfg_err) begin
                  res_status_in = STATUS_CFG_ERR;
                  state_in      = ST_EMIT;
               end else begin
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            // one quotient bit per cycle
            rem_in  = diff[32] ? trial[31:0] : diff[31:0];
            word_in = {word_ff[WORD_W-2:0], 1'b0};
            step_in = step_ff + STEP_W'(1);
            if (step_ff == LAST_STEP) begin
               state_in = ST_LIT;
            end
         end
         ST_LIT: begin
            // fold remainder into sign and magnitude
            if (rem_ff < {1'b0, nvars_ff}) begin
               mag_in = rem_ff[NVARS_W-1:0] + NVARS_W'(1);
               neg_in = 1'b0;
            end else begin
               mag_in = neg_mag[NVARS_W-1:0];
               neg_in = 1'b1;
            end
            scan_in    = '0;
            chk_vld_in = 1'b0;
            state_in   = ST_SCAN;
         end
         ST_SCAN: begin
            // stop on a hit, accept once every stored entry is compared
            if (match) begin
               res_status_in = STATUS_REPEAT;
               chk_vld_in    = 1'b0;
               state_in      = ST_EMIT;
            end else if (!issue) begin
               res_status_in = STATUS_ACCEPT;
               state_in      = ST_EMIT;
            end else begin
               chk_vld_in = issue;
               if (issue) begin
                  scan_in = scan_ff + AW'(1);
               end
            end
         end
         ST_EMIT: begin
            // load the result register once it is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_lit_in    = '0;
               rsp_cdone_in  = 1'b0;
               rsp_fdone_in  = 1'b0;
               if (res_status_ff == STATUS_ACCEPT) begin
                  rsp_lit_in = lit_val;
                  if (clause_end) begin
                     rsp_cdone_in = 1'b1;
                     pos_in       = '0;
                     if (formula_end) begin
                        rsp_fdone_in = 1'b1;
                        ccount_in    = '0;
                     end else begin
                        ccount_in = ccount_ff + NCL_W'(1);
                     end
                  end else begin
                     pos_in = pos_ff + AW'(1);
                  end
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         nvars_ff     <= VAR_COUNT_RST;
         cwidth_ff    <= CLAUSE_WIDTH_RST;
         nclauses_ff  <= NUM_CLAUSES_RST;
         state_ff     <= ST_IDLE;
         chk_vld_ff   <= 1'b0;
         pos_ff       <= '0;
         ccount_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         nvars_ff     <= nvars_in;
         cwidth_ff    <= cwidth_in;
         nclauses_ff  <= nclauses_in;
         state_ff     <= state_in;
         chk_vld_ff   <= chk_vld_in;
         pos_ff       <= pos_in;
         ccount_ff    <= ccount_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      word_ff       <= word_in;
      rem_ff        <= rem_in;
      step_ff       <= step_in;
      mag_ff        <= mag_in;
      neg_ff        <= neg_in;
      scan_ff       <= scan_in;
      res_status_ff <= res_status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_lit_ff    <= rsp_lit_in;
      rsp_cdone_ff  <= rsp_cdone_in;
      rsp_fdone_ff  <= rsp_fdone_in;
   end

   // ports
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_lit_ff;
   assign rsp_tuser  = {rsp_fdone_ff, rsp_status_ff};
   assign rsp_tlast  = rsp_cdone_ff;

endmodule
